// ===== rtl/ddo_pkg.sv =====
// shared types, constants and tables for the wheel odometry block
package ddo_pkg;

  localparam int unsigned MulLen  = 36;
  localparam int unsigned DivLen  = 84;
  localparam int unsigned CntW    = 7;
  localparam int unsigned AccW    = 100;
  localparam int unsigned NumW    = 84;
  localparam int unsigned XyW     = 60;
  localparam int unsigned ZW      = 34;

  localparam logic [31:0] CordicGain = 32'h9B74EDA8;
  localparam logic [35:0] UsPerSec   = 36'd1000000;

  localparam logic [31:0] DptReset   = 32'd367014;
  localparam logic [35:0] TpmReset   = 36'd2896475000;
  localparam logic [31:0] DdbReset   = 32'd42950;
  localparam logic [31:0] TdbReset   = 32'd6836;
  localparam logic [31:0] StaleReset = 32'd1000000000;

  typedef enum logic [2:0] {
    REG_DPT   = 3'd0,
    REG_TPM   = 3'd1,
    REG_DDB   = 3'd2,
    REG_TDB   = 3'd3,
    REG_STALE = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_D,
    OP_MUL_A,
    OP_MUL_TH,
    OP_MUL_G,
    OP_ROT,
    OP_POSE,
    OP_NUM_L,
    OP_DIV_L,
    OP_NUM_A,
    OP_DIV_A
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_D,
    S_MUL_A,
    S_MUL_TH,
    S_MUL_G,
    S_ROT,
    S_POSE,
    S_NUM_L,
    S_DIV_L,
    S_NUM_A,
    S_DIV_A,
    S_PUB
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   publish;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic move;
    logic valid;
  } dp_status_t;

  typedef struct packed {
    logic [31:0] dpt;
    logic [35:0] tpm;
    logic [31:0] ddb;
    logic [31:0] tdb;
    logic [31:0] stale;
  } cfg_t;

  // arctangent of 2^-k in 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ddo_cfg.sv =====
// configuration registers behind the apb port
module ddo_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [5:0]    paddr_i,
  input  logic [63:0]   pwdata_i,
  output logic [63:0]   prdata_o,
  output logic          pready_o,
  output ddo_pkg::cfg_t cfg_o
);
  import ddo_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx      = reg_idx_e'(paddr_i[5:3]);
  assign wr       = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_DPT:   cfg_d.dpt   = pwdata_i[31:0];
        REG_TPM:   cfg_d.tpm   = pwdata_i[35:0];
        REG_DDB:   cfg_d.ddb   = pwdata_i[31:0];
        REG_TDB:   cfg_d.tdb   = pwdata_i[31:0];
        REG_STALE: cfg_d.stale = pwdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DPT:   prdata_o = {32'd0, cfg_q.dpt};
      REG_TPM:   prdata_o = {28'd0, cfg_q.tpm};
      REG_DDB:   prdata_o = {32'd0, cfg_q.ddb};
      REG_TDB:   prdata_o = {32'd0, cfg_q.tdb};
      REG_STALE: prdata_o = {32'd0, cfg_q.stale};
      default:   prdata_o = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dpt   <= DptReset;
      cfg_q.tpm   <= TpmReset;
      cfg_q.ddb   <= DdbReset;
      cfg_q.tdb   <= TdbReset;
      cfg_q.stale <= StaleReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/ddo_ctrl.sv =====
// sequencer that steps the odometry datapath through one reading
module ddo_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ddo_pkg::dp_status_t status_i,
  output ddo_pkg::dp_cmd_t    cmd_o
);
  import ddo_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    cmd_o.publish = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_LOAD;
          state_d  = status_i.first ? S_IDLE : S_MUL_D;
        end
      end
      S_MUL_D: begin
        cmd_o.op = OP_MUL_D;
        if (status_i.last) state_d = S_MUL_A;
      end
      S_MUL_A: begin
        cmd_o.op = OP_MUL_A;
        if (status_i.last) state_d = S_MUL_TH;
      end
      S_MUL_TH: begin
        cmd_o.op = OP_MUL_TH;
        if (status_i.last) state_d = status_i.move ? S_MUL_G : S_POSE;
      end
      S_MUL_G: begin
        cmd_o.op = OP_MUL_G;
        if (status_i.last) state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.op = OP_ROT;
        if (status_i.last) state_d = S_POSE;
      end
      S_POSE: begin
        cmd_o.op = OP_POSE;
        state_d  = status_i.valid ? S_NUM_L : S_PUB;
      end
      S_NUM_L: begin
        cmd_o.op = OP_NUM_L;
        if (status_i.last) state_d = S_DIV_L;
      end
      S_DIV_L: begin
        cmd_o.op = OP_DIV_L;
        if (status_i.last) state_d = S_NUM_A;
      end
      S_NUM_A: begin
        cmd_o.op = OP_NUM_A;
        if (status_i.last) state_d = S_DIV_A;
      end
      S_DIV_A: begin
        cmd_o.op = OP_DIV_A;
        if (status_i.last) state_d = S_PUB;
      end
      S_PUB: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_pub_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a pending beat");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !status_i.first) |=> (state_q == S_MUL_D))
    else $error("accepted reading did not start the sequence");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_A && status_i.last) |=> (state_q == S_PUB))
    else $error("division end did not lead to publish");

endmodule

// ===== rtl/ddo_datapath.sv =====
// odometry datapath: shift-add multiplier, cordic rotator, radix-2 divider, pose
module ddo_datapath #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddo_pkg::cfg_t       cfg_i,
  input  ddo_pkg::dp_cmd_t    cmd_i,
  output ddo_pkg::dp_status_t status_o,
  input  logic [31:0]         left_count_i,
  input  logic [31:0]         right_count_i,
  input  logic [31:0]         elapsed_us_i,
  output logic [39:0]         position_x_o,
  output logic [39:0]         position_y_o,
  output logic [31:0]         heading_o,
  output logic [31:0]         linear_velocity_o,
  output logic [31:0]         angular_velocity_o,
  output logic                velocity_valid_o
);
  import ddo_pkg::*;

  // control state
  logic              first_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [39:0]       pose_x_q, pose_y_q;
  logic [31:0]       heading_q;
  logic [31:0]       prev_l_q, prev_r_q;

  // payload
  logic [32:0]       smag_q, tmag_q;
  logic              dneg_q, tneg_q, valid_q;
  logic [31:0]       elapsed_q;
  logic [63:0]       dmag_q, a_q, thmag_q;
  logic [31:0]       thwrap_q;
  logic [55:0]       xmag_q;
  logic [AccW-1:0]   acc_q, acc_d, mcand_q, mcand_d;
  logic [35:0]       mplier_q, mplier_d;
  logic signed [XyW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]  z_q, z_d;
  logic [NumW-1:0]   num_q, numsh_q, numsh_d;
  logic [47:0]       rem_q, rem_d;
  logic [31:0]       quo_q, quo_d;
  logic [31:0]       lin_q, ang_q;
  logic [39:0]       ox_q, oy_q;
  logic [31:0]       oh_q, olin_q, oang_q;
  logic              ov_q;

  logic [CntW-1:0]   op_len;
  logic              last;
  logic [31:0]       dl, dr;
  logic [33:0]       s, t;
  logic [32:0]       smag, tmag;
  logic              vld;
  logic [63:0]       mul_a;
  logic [35:0]       mul_b;
  logic [4:0]        k;
  logic signed [XyW-1:0] xs, ys, x0;
  logic [31:0]       phi, phq;
  logic [48:0]       rem_sh;
  logic [47:0]       divisor;
  logic              ge;

  function automatic logic [31:0] sat_rate(input logic [31:0] q, input logic neg);
    logic [31:0] r;
    if (neg) r = q[31] ? 32'h80000000 : 32'(-q);
    else     r = q[31] ? 32'h7FFFFFFF : q;
    return r;
  endfunction

  always_comb begin
    case (cmd_i.op) inside
      OP_MUL_D, OP_MUL_A, OP_MUL_TH, OP_MUL_G, OP_NUM_L, OP_NUM_A:
        op_len = CntW'(MulLen);
      OP_ROT:             op_len = CntW'(CORDIC_STEPS);
      OP_DIV_L, OP_DIV_A: op_len = CntW'(DivLen);
      default:            op_len = '0;
    endcase
  end

  assign last = (cnt_q == op_len);
  assign cnt_d = (cmd_i.op == OP_NONE || last) ? '0 : cnt_q + CntW'(1);

  assign status_o.first = first_q;
  assign status_o.last  = last;
  assign status_o.move  = dmag_q > {32'd0, cfg_i.ddb};
  assign status_o.valid = valid_q;

  // reading differences
  assign dl   = left_count_i - prev_l_q;
  assign dr   = right_count_i - prev_r_q;
  assign s    = {{2{dl[31]}}, dl} + {{2{dr[31]}}, dr};
  assign t    = {{2{dr[31]}}, dr} - {{2{dl[31]}}, dl};
  assign smag = s[33] ? 33'(-s) : s[32:0];
  assign tmag = t[33] ? 33'(-t) : t[32:0];
  assign vld  = (elapsed_us_i != 32'd0) && (elapsed_us_i < cfg_i.stale);

  // multiplier operand select
  always_comb begin
    case (cmd_i.op)
      OP_MUL_D:  begin mul_a = {32'd0, cfg_i.dpt}; mul_b = {3'd0, smag_q}; end
      OP_MUL_A:  begin mul_a = {32'd0, cfg_i.dpt}; mul_b = {3'd0, tmag_q}; end
      OP_MUL_TH: begin mul_a = a_q;                mul_b = cfg_i.tpm;      end
      OP_MUL_G:  begin mul_a = {8'd0, dmag_q[63:8]}; mul_b = {4'd0, CordicGain}; end
      OP_NUM_L:  begin mul_a = dmag_q;             mul_b = UsPerSec;       end
      default:   begin mul_a = thmag_q;            mul_b = UsPerSec;       end
    endcase
  end

  always_comb begin
    if (cnt_q == '0) begin
      acc_d    = '0;
      mcand_d  = {36'd0, mul_a};
      mplier_d = mul_b;
    end else begin
      acc_d    = acc_q + (mplier_q[0] ? mcand_q : '0);
      mcand_d  = {mcand_q[AccW-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[35:1]};
    end
  end

  // cordic
  assign k   = 5'(cnt_q - CntW'(1));
  assign xs  = x_q >>> k;
  assign ys  = y_q >>> k;
  assign x0  = dneg_q ? -$signed({4'd0, xmag_q}) : $signed({4'd0, xmag_q});
  assign phi = heading_q - thwrap_q;
  assign phq = phi + 32'h40000000;

  always_comb begin
    if (cnt_q == '0) begin
      y_d = '0;
      if (phq[31]) begin
        x_d = -x0;
        z_d = $signed({{2{~phi[31]}}, ~phi[31], phi[30:0]});
      end else begin
        x_d = x0;
        z_d = $signed({{2{phi[31]}}, phi});
      end
    end else if (!z_q[ZW-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - $signed({2'd0, atan_turn(k)});
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + $signed({2'd0, atan_turn(k)});
    end
  end

  // restoring divider, quotient held once it reaches 2^31
  assign divisor = {elapsed_q, 16'd0};
  assign rem_sh  = {rem_q, numsh_q[NumW-1]};
  assign ge      = rem_sh >= {1'b0, divisor};

  always_comb begin
    if (cnt_q == '0) begin
      rem_d   = '0;
      quo_d   = '0;
      numsh_d = num_q;
    end else begin
      rem_d   = ge ? 48'(rem_sh - {1'b0, divisor}) : rem_sh[47:0];
      quo_d   = quo_q[31] ? quo_q : {quo_q[30:0], ge};
      numsh_d = {numsh_q[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= 1'b1;
      cnt_q     <= '0;
      prev_l_q  <= '0;
      prev_r_q  <= '0;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.op == OP_LOAD) begin
        first_q  <= 1'b0;
        prev_l_q <= left_count_i;
        prev_r_q <= right_count_i;
      end
      if (cmd_i.op == OP_POSE) begin
        if (status_o.move) begin
          pose_x_q <= pose_x_q + x_q[47:8];
          pose_y_q <= pose_y_q + y_q[47:8];
        end
        if (thmag_q > {32'd0, cfg_i.tdb}) heading_q <= heading_q + thwrap_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      smag_q    <= smag;
      tmag_q    <= tmag;
      dneg_q    <= s[33];
      tneg_q    <= t[33];
      valid_q   <= vld;
      elapsed_q <= elapsed_us_i;
    end
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    numsh_q  <= numsh_d;
    if (last) begin
      case (cmd_i.op) inside
        OP_MUL_D: dmag_q <= acc_d[64:1];
        OP_MUL_A: a_q    <= acc_d[63:0];
        OP_MUL_TH: begin
          thmag_q  <= (|acc_d[99:96]) ? '1 : acc_d[95:32];
          thwrap_q <= tneg_q ? 32'(-acc_d[63:32]) : acc_d[63:32];
        end
        OP_MUL_G: xmag_q <= acc_d[87:32];
        OP_NUM_L, OP_NUM_A: num_q <= acc_d[NumW-1:0];
        OP_DIV_L: lin_q <= sat_rate(quo_d, dneg_q);
        OP_DIV_A: ang_q <= sat_rate(quo_d, tneg_q);
        default: ;
      endcase
    end
    if (cmd_i.publish) begin
      ox_q   <= pose_x_q;
      oy_q   <= pose_y_q;
      oh_q   <= heading_q;
      olin_q <= valid_q ? lin_q : 32'd0;
      oang_q <= valid_q ? ang_q : 32'd0;
      ov_q   <= valid_q;
    end
  end

  assign position_x_o       = ox_q;
  assign position_y_o       = oy_q;
  assign heading_o          = oh_q;
  assign linear_velocity_o  = olin_q;
  assign angular_velocity_o = oang_q;
  assign velocity_valid_o   = ov_q;

endmodule

// ===== rtl/differential_drive_odometry_top.sv =====
// top level of the differential drive wheel odometry block
// Usage:
//   s_axis carries one encoder reading per beat: left and right running
//   counts and the microseconds since the previous reading.
//   m_axis carries the updated pose (x, y, heading) and the two speeds;
//   tuser flags whether the speeds are valid.
//   The apb port holds five 64-bit-spaced registers (address 8*index).
// Operation:
//   The first reading after reset only latches the counts and gives no beat.
//   A later reading runs through one shared shift-add multiplier, a cordic
//   rotator and a radix-2 divider; the rotator is skipped when the robot is
//   still and the divider when the interval is stale.
//   One reading is in flight at a time; s_axis_tready is high only between.
// Reset clears the pose, the previous counts and the configuration to its
// defaults. If m_axis stalls, the result waits in the output register while
// the next reading is accepted and processed; its result waits until the
// earlier beat is taken.
module differential_drive_odometry_top #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,   // left_count, right_count, elapsed_us
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // position_x, position_y, heading, linear_velocity, angular_velocity
  output logic [175:0]  m_axis_tdata,
  output logic          m_axis_tuser,   // velocity_valid
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import ddo_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  ddo_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ddo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .status_o           (status),
    .left_count_i       (s_axis_tdata[31:0]),
    .right_count_i      (s_axis_tdata[63:32]),
    .elapsed_us_i       (s_axis_tdata[95:64]),
    .position_x_o       (m_axis_tdata[39:0]),
    .position_y_o       (m_axis_tdata[79:40]),
    .heading_o          (m_axis_tdata[111:80]),
    .linear_velocity_o  (m_axis_tdata[143:112]),
    .angular_velocity_o (m_axis_tdata[175:144]),
    .velocity_valid_o   (m_axis_tuser)
  );

endmodule

// ===== dv/tb.sv =====
// testbench for the differential drive wheel odometry block
`timescale 1ns / 1ps

module tb;
  import ddo_pkg::*;

  localparam int unsigned CordicSteps = 24;
  localparam longint unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 600;
  localparam logic [31:0] GainQ32 = 32'h9B74EDA8;
  localparam logic [31:0] AtanTurn [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [39:0] pos_x;
    logic [39:0] pos_y;
    logic [31:0] heading;
    logic [31:0] lin_vel;
    logic [31:0] ang_vel;
    logic        vel_valid;
  } pose_t;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] elapsed;
    bit          typed;
    pose_t       pose;
  } reading_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;   // left_count, right_count, elapsed_us
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // position_x, position_y, heading, linear_velocity, angular_velocity
  logic [175:0] m_axis_tdata;
  logic         m_axis_tuser;   // velocity_valid
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [5:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  differential_drive_odometry_top #(
    .CORDIC_STEPS(CordicSteps)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // odometry shadow: configuration and pose
  logic [31:0] cfg_dpt, cfg_ddb, cfg_tdb, cfg_stale;
  logic [35:0] cfg_tpm;
  bit          await_first;
  logic [31:0] prev_left, prev_right, pose_heading;
  logic [39:0] pose_x, pose_y;

  pose_t       pose_queue[$];
  int unsigned mismatches;
  bit          no_idle;
  longint unsigned cycles;
  logic [31:0] last_left, last_right;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] speed(input logic [63:0] mag, input bit neg,
                                        input logic [31:0] elapsed);
    logic [127:0] q;
    q = (128'(mag) * 128'd1000000) / (128'(elapsed) << 16);
    if (neg) return (q >= 128'h80000000) ? 32'h80000000 : -q[31:0];
    return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
  endfunction

  // advances the pose by one reading; returns 0 for the latching reading
  function automatic bit odometry_step(input logic [31:0] left, right, elapsed,
                                       output pose_t res);
    int            dl, dr;
    longint        s, t, x, y, z, xs, ys;
    logic [63:0]   smag, tmag, dmag, a, thmag, xmag;
    logic [127:0]  p;
    logic [31:0]   thw, phi;
    bit            dneg, tneg, valid;
    res = '0;
    if (await_first) begin
      await_first = 0;
      prev_left = left;
      prev_right = right;
      return 0;
    end
    dl = left - prev_left;
    dr = right - prev_right;
    prev_left = left;
    prev_right = right;
    s = longint'(dl) + longint'(dr);
    t = longint'(dr) - longint'(dl);
    dneg = s < 0;
    tneg = t < 0;
    smag = dneg ? -s : s;
    tmag = tneg ? -t : t;
    dmag = (smag * 64'(cfg_dpt)) >> 1;
    a = tmag * 64'(cfg_dpt);
    p = 128'(a) * 128'(cfg_tpm);
    thmag = (p[127:96] != 0) ? '1 : p[95:32];
    thw = p[63:32];
    if (tneg) thw = -thw;
    if (dmag > 64'(cfg_ddb)) begin
      phi = pose_heading - thw;
      p = 128'(dmag >> 8) * 128'(GainQ32);
      xmag = p[95:32];
      x = dneg ? -longint'(xmag) : longint'(xmag);
      y = 0;
      // rotation beyond a quarter turn: flip first
      if (32'(phi + 32'h40000000) >= 32'h80000000) begin
        x = -x;
        phi = phi - 32'h80000000;
      end
      z = longint'($signed(phi));
      for (int k = 0; k < CordicSteps; k++) begin
        xs = x >>> (k & 31);
        ys = y >>> (k & 31);
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= longint'(AtanTurn[k & 31]);
        end else begin
          x += ys;
          y -= xs;
          z += longint'(AtanTurn[k & 31]);
        end
      end
      pose_x = pose_x + 40'(x >>> 8);
      pose_y = pose_y + 40'(y >>> 8);
    end
    if (thmag > 64'(cfg_tdb)) pose_heading = pose_heading + thw;
    valid = (elapsed != 0) && (elapsed < cfg_stale);
    res.pos_x = pose_x;
    res.pos_y = pose_y;
    res.heading = pose_heading;
    res.lin_vel = valid ? speed(dmag, dneg, elapsed) : '0;
    res.ang_vel = valid ? speed(thmag, tneg, elapsed) : '0;
    res.vel_valid = valid;
    return 1;
  endfunction

  task automatic reg_write(input reg_idx_e idx, input logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_DPT:   cfg_dpt = value[31:0];
      REG_TPM:   cfg_tpm = value[35:0];
      REG_DDB:   cfg_ddb = value[31:0];
      REG_TDB:   cfg_tdb = value[31:0];
      REG_STALE: cfg_stale = value[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pose_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] dpt, input logic [35:0] tpm,
                            input logic [31:0] ddb, tdb, stale);
    drain();
    reg_write(REG_DPT, 64'(dpt));
    reg_write(REG_TPM, 64'(tpm));
    reg_write(REG_DDB, 64'(ddb));
    reg_write(REG_TDB, 64'(tdb));
    reg_write(REG_STALE, 64'(stale));
  endtask

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send(input reading_t rd);
    pose_t res;
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rd.elapsed, rd.right, rd.left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (odometry_step(rd.left, rd.right, rd.elapsed, res))
      pose_queue.push_back(rd.typed ? rd.pose : res);
    last_left = rd.left;
    last_right = rd.right;
    @(negedge clk_i);
  endtask

  task automatic stop_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic random_readings(input int unsigned count);
    reading_t rd;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      rd.typed = 0;
      rd.pose = '0;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        rd.left = last_left + 32'($urandom_range(0, 4000)) - 32'd2000;
        rd.right = last_right + 32'($urandom_range(0, 4000)) - 32'd2000;
      end else if (pick < 80) begin
        rd.left = last_left;
        rd.right = last_right;
      end else if (pick < 90) begin
        rd.left = last_left + 32'($urandom_range(0, 400000)) - 32'd200000;
        rd.right = rd.left - last_left + last_right + 32'($urandom_range(0, 20)) - 32'd10;
      end else begin
        rd.left = $urandom;
        rd.right = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) rd.elapsed = $urandom_range(1000, 50000);
      else if (pick < 82) rd.elapsed = '0;
      else if (pick < 88) rd.elapsed = $urandom_range(1, 8);
      else if (pick < 94) rd.elapsed = cfg_stale + 32'($urandom_range(0, 2)) - 32'd1;
      else rd.elapsed = $urandom;
      send(rd);
    end
    stop_stream();
  endtask

  // output side: random stalls, checked at the rising edge
  initial begin
    pose_t got, want;
    int unsigned wait_cycles;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 6);
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = {m_axis_tdata[39:0], m_axis_tdata[79:40], m_axis_tdata[111:80],
             m_axis_tdata[143:112], m_axis_tdata[175:144], m_axis_tuser};
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h", got);
      end else begin
        want = pose_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch x %h/%h y %h/%h hdg %h/%h lin %h/%h ang %h/%h ok %b/%b",
                     want.pos_x, got.pos_x, want.pos_y, got.pos_y, want.heading,
                     got.heading, want.lin_vel, got.lin_vel, want.ang_vel, got.ang_vel,
                     want.vel_valid, got.vel_valid);
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    reading_t table_rows[$];
    clk_i = 1'b0;
    cycles = 0;
    mismatches = 0;
    no_idle = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_dpt = 32'd367014;
    cfg_tpm = 36'd2896475000;
    cfg_ddb = 32'd42950;
    cfg_tdb = 32'd6836;
    cfg_stale = 32'd1000000000;
    await_first = 1;
    prev_left = '0;
    prev_right = '0;
    pose_x = '0;
    pose_y = '0;
    pose_heading = '0;
    last_left = '0;
    last_right = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // left, right, elapsed, typed expectation, expected pose
    table_rows = '{
      '{32'd5, 32'd7, 32'd3, 1'b0, '0},                     // first reading latches only
      '{32'd5, 32'd7, 32'd0, 1'b1, '0},                     // still, zero interval
      '{32'd5, 32'd7, 32'd1000, 1'b1, {176'd0, 1'b1}},      // still, valid interval
      '{32'd1005, 32'd1007, 32'd20000, 1'b0, '0},           // straight ahead
      '{32'd5, 32'd7, 32'd20000, 1'b0, '0},                 // straight back
      '{32'd4, 32'd8, 32'd10000, 1'b0, '0},                 // below the distance deadband
      '{32'd3, 32'd9, 32'd10000, 1'b0, '0},                 // turn on the spot
      '{32'd403, 32'd9, 32'd10000, 1'b0, '0},               // right turn
      '{32'd503, 32'd909, 32'd1, 1'b0, '0},                 // tiny interval, saturation
      '{32'h7FFFFFFF, 32'h80000000, 32'd5000, 1'b0, '0},    // extreme counts
      '{32'h80000000, 32'h7FFFFFFF, 32'd5000, 1'b0, '0},    // counter wrap
      '{32'h80000001, 32'h80000000, 32'hFFFFFFFF, 1'b0, '0}, // stale interval
      '{32'h80000001, 32'h80000000, 32'd999999999, 1'b0, '0}, // just below stale
      '{32'h80000001, 32'h80000000, 32'd1000000000, 1'b0, '0}, // at stale limit
      '{32'hFFFFFFFF, 32'h00000000, 32'd7777, 1'b0, '0},
      '{32'h00000000, 32'hFFFFFFFF, 32'd7777, 1'b0, '0},
      '{32'h0000C000, 32'h00010000, 32'd30000, 1'b0, '0},
      '{32'h00020000, 32'h00018000, 32'd30000, 1'b0, '0}
    };
    foreach (table_rows[i]) send(table_rows[i]);
    random_readings(230);

    set_config($urandom, {4'($urandom), 32'($urandom)}, $urandom_range(0, 200000),
               $urandom_range(0, 200000), $urandom_range(50000, 2000000));
    random_readings(250);

    set_config(32'hFFFFFFFF, 36'hFFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    random_readings(250);

    set_config(32'd1, 36'd1, 32'd0, 32'd0, 32'd1);
    random_readings(150);

    set_config(32'd367014, 36'd2896475000, 32'd0, 32'd0, 32'd40000);
    random_readings(150);

    set_config($urandom_range(100000, 3000000), 36'($urandom_range(1, 32'hFFFFFFFF)) << 2,
               $urandom_range(0, 100000), $urandom_range(0, 100000), $urandom);
    random_readings(200);

    drain();
    if (mismatches == 0 && pose_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
